// ===== design/qsvge_pkg.sv =====
// Shared types, constants and arithmetic helpers for the state-vector gate engine.
package qsvge_pkg;

    // Store geometry
    localparam int QUBITS = 10;
    localparam int ADDR_W = QUBITS;
    localparam int NENT   = 1 << QUBITS;
    localparam int PAIR_W = (QUBITS > 1) ? QUBITS - 1 : 1;
    localparam int NPAIR  = 1 << (QUBITS - 1);

    // Field widths
    localparam int AMP_W     = 16;
    localparam int FRAC_W    = 14;
    localparam int IDX_W     = 10;
    localparam int QB_W      = 4;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 2 * AMP_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int QUO_W     = SUM_W - FRAC_W + 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CNOT  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EQUAL = 2'd2;

    // Gate register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_M00_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M00_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M01_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M01_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_M10_RE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_M10_IM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_M11_RE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_M11_IM = 3'd7;

    localparam logic signed [AMP_W-1:0] ONE_Q = 16'sd16384;

    typedef struct packed {
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
    } t_amp;

    typedef struct packed {
        t_amp m00;
        t_amp m01;
        t_amp m10;
        t_amp m11;
    } t_gate;

    // Sweep read tag: row 0 is the entry with the target bit clear
    typedef struct packed {
        logic              valid;
        logic              row;
        logic [ADDR_W-1:0] addr;
    } t_tag;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        t_amp              data;
    } t_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd;

    typedef struct packed {
        logic              cnot;
        logic [ADDR_W-1:0] cmask;
    } t_mode;

    typedef struct packed {
        logic            load;
        logic            is_read;
        logic [ST_W-1:0] status;
    } t_done;

    // Round to nearest (ties upward) and saturate a Q6.28 sum to Q2.14
    function automatic logic signed [AMP_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0]   b;
        logic signed [QUO_W-1:0] q;
        logic signed [QUO_W-1:0] hi;
        logic signed [QUO_W-1:0] lo;
        b  = {s[SUM_W-1], s} + (SUM_W + 1)'(1 << (FRAC_W - 1));
        q  = b[SUM_W:FRAC_W];
        hi = QUO_W'(32767);
        lo = QUO_W'(-32768);
        if (q > hi) begin
            round_sat = 16'sh7FFF;
        end else if (q < lo) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[AMP_W-1:0];
        end
    endfunction

endpackage

// ===== design/qsvge_store.sv =====
// Amplitude store: one write port, one read port, registered read data.
module qsvge_store import qsvge_pkg::*; (
    input  logic i_clk,
    input  t_wr  i_wr,
    input  t_rd  i_rd,
    output t_amp o_rdata
);

    t_amp mem [NENT];
    t_amp r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/qsvge_bfly.sv =====
// Pair datapath: gathers an amplitude pair, applies the 2x2 gate or the swap, writes back.
module qsvge_bfly import qsvge_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_amp  i_rdata,
    input  t_tag  i_tag,
    input  t_mode i_mode,
    input  t_gate i_gate,
    output t_wr   o_wr,
    output logic  o_busy
);

    t_tag r_t1, r_t2, r_t3;
    t_amp r_a0, r_x0, r_x1;

    logic                     r_m_valid;
    logic [ADDR_W-1:0]        r_m_addr;
    logic signed [PROD_W-1:0] r_p [8];
    t_amp                     r_m_amp;

    logic                     r_s_valid;
    logic [ADDR_W-1:0]        r_s_addr;
    logic signed [SUM_W-1:0]  r_sr, r_si;
    t_amp                     r_s_amp;

    t_wr  r_wr;

    t_amp c0, c1, pick;
    logic swap;

    // Tag delay line: valid bits under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_s_valid  <= 1'b0;
            r_wr.valid <= 1'b0;
        end else begin
            r_t1.valid <= i_tag.valid;
            r_t2.valid <= r_t1.valid;
            r_t3.valid <= r_t2.valid;
            r_m_valid  <= r_t3.valid;
            r_s_valid  <= r_m_valid;
            r_wr.valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1.row  <= i_tag.row;
        r_t1.addr <= i_tag.addr;
        r_t2.row  <= r_t1.row;
        r_t2.addr <= r_t1.addr;
        r_t3.row  <= r_t2.row;
        r_t3.addr <= r_t2.addr;
    end

    // Hold the first amplitude, then latch the whole pair for two rows
    always_ff @(posedge i_clk) begin
        if (r_t1.valid && !r_t1.row) begin
            r_a0 <= i_rdata;
        end
        if (r_t1.valid && r_t1.row) begin
            r_x0 <= r_a0;
            r_x1 <= i_rdata;
        end
    end

    always_comb begin
        c0   = r_t3.row ? i_gate.m10 : i_gate.m00;
        c1   = r_t3.row ? i_gate.m11 : i_gate.m01;
        swap = (r_t3.addr & i_mode.cmask) != '0;
        pick = (r_t3.row ^ swap) ? r_x1 : r_x0;
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        r_m_addr <= r_t3.addr;
        r_m_amp  <= pick;
        r_p[0]   <= c0.re * r_x0.re;
        r_p[1]   <= c0.im * r_x0.im;
        r_p[2]   <= c1.re * r_x1.re;
        r_p[3]   <= c1.im * r_x1.im;
        r_p[4]   <= c0.re * r_x0.im;
        r_p[5]   <= c0.im * r_x0.re;
        r_p[6]   <= c1.re * r_x1.im;
        r_p[7]   <= c1.im * r_x1.re;
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        r_s_addr <= r_m_addr;
        r_s_amp  <= r_m_amp;
        r_sr     <= SUM_W'(r_p[0]) - SUM_W'(r_p[1]) + SUM_W'(r_p[2]) - SUM_W'(r_p[3]);
        r_si     <= SUM_W'(r_p[4]) + SUM_W'(r_p[5]) + SUM_W'(r_p[6]) + SUM_W'(r_p[7]);
    end

    // Round and saturate the gate result, or pass the swapped amplitude for CNOT, and stage the write-back
    always_ff @(posedge i_clk) begin
        r_wr.addr <= r_s_addr;
        if (i_mode.cnot) begin
            r_wr.data <= r_s_amp;
        end else begin
            r_wr.data.re <= round_sat(r_sr);
            r_wr.data.im <= round_sat(r_si);
        end
    end

    assign o_wr   = r_wr;
    assign o_busy = r_t1.valid | r_t2.valid | r_t3.valid | r_m_valid | r_s_valid | r_wr.valid;

endmodule

// ===== design/qsvge_ctrl.sv =====
// Command sequencer: decodes beats, checks qubits, drives the pair sweep.
module qsvge_ctrl import qsvge_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [IDX_W-1:0]        i_amp_index,
    input  logic signed [AMP_W-1:0] i_amp_re,
    input  logic signed [AMP_W-1:0] i_amp_im,
    input  logic [QB_W-1:0]         i_target_qubit,
    input  logic [QB_W-1:0]         i_control_qubit,
    input  logic                    i_busy,
    input  logic                    i_out_free,
    output t_wr                     o_hwr,
    output t_rd                     o_rd,
    output t_tag                    o_tag,
    output t_mode                   o_mode,
    output t_done                   o_done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [PAIR_W-1:0] r_pair;
    logic              r_phase;
    logic [ADDR_W-1:0] r_tmask, r_cmask;
    logic              r_cnot, r_is_read;
    logic [ST_W-1:0]   r_status;

    logic              accept, last, tq_bad, cq_bad, sweep_cmd;
    logic [ST_W-1:0]   st;
    logic [ADDR_W-1:0] pe, lo, i0, i1, idx, saddr;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign idx     = ADDR_W'(i_amp_index);
    assign tq_bad  = 32'(i_target_qubit) >= QUBITS;
    assign cq_bad  = 32'(i_control_qubit) >= QUBITS;
    assign sweep_cmd = (i_cmd == CMD_GATE) || (i_cmd == CMD_CNOT);
    assign last    = r_pair == PAIR_W'(NPAIR - 1);

    always_comb begin
        case (i_cmd)
            CMD_GATE: st = tq_bad ? ST_RANGE : ST_OK;
            CMD_CNOT: begin
                if (tq_bad || cq_bad) begin
                    st = ST_RANGE;
                end else if (i_target_qubit == i_control_qubit) begin
                    st = ST_EQUAL;
                end else begin
                    st = ST_OK;
                end
            end
            default: st = ST_OK;
        endcase
    end

    // Insert a clear target bit into the pair number to get the row-0 index
    always_comb begin
        pe    = ADDR_W'(r_pair);
        lo    = r_tmask - ADDR_W'(1);
        i0    = ((pe & ~lo) << 1) | (pe & lo);
        i1    = i0 | r_tmask;
        saddr = r_phase ? i1 : i0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (sweep_cmd && st == ST_OK) ? S_SWEEP : S_FIN;
                end
            end
            S_SWEEP: begin
                if (r_phase && last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pair  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_pair <= r_pair + PAIR_W'(1);
                end
            end else begin
                r_phase <= 1'b0;
                r_pair  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tmask   <= ADDR_W'(1) << i_target_qubit;
            r_cmask   <= ADDR_W'(1) << i_control_qubit;
            r_cnot    <= (i_cmd == CMD_CNOT);
            r_is_read <= (i_cmd == CMD_READ);
            r_status  <= st;
        end
    end

    always_comb begin
        o_hwr.valid   = accept && (i_cmd == CMD_WRITE);
        o_hwr.addr    = idx;
        o_hwr.data.re = i_amp_re;
        o_hwr.data.im = i_amp_im;

        o_rd.en   = (accept && (i_cmd == CMD_READ)) || (r_state == S_SWEEP);
        o_rd.addr = (r_state == S_SWEEP) ? saddr : idx;

        o_tag.valid = (r_state == S_SWEEP);
        o_tag.row   = r_phase;
        o_tag.addr  = saddr;

        o_mode.cnot  = r_cnot;
        o_mode.cmask = r_cmask;

        o_done.load    = (r_state == S_FIN) && i_out_free;
        o_done.is_read = r_is_read;
        o_done.status  = r_status;
    end

endmodule

// ===== design/quantum_state_vector_gate_engine.sv =====
// Top level of the state-vector gate engine: gate registers, store, sequencer, result register.
//
// Holds 2^QUBITS complex amplitudes (Q2.14 real and imaginary) in one synchronous
// RAM with a single write and a single registered read port. Each input beat is a
// command: write one amplitude, read one amplitude, apply the configured 2x2 gate to
// a target qubit, or apply CNOT(control, target); each gives exactly one result beat
// carrying the read data (zero unless a read) and a status code. A write or read, and
// any command rejected for a bad qubit, skips the sweep and goes straight to its result. A
// gate or CNOT sweeps every amplitude pair through the RAM: the read port fetches
// one amplitude per cycle, so a sweep issues 2^QUBITS reads, then drains a six-stage
// read/multiply/sum/round pipeline whose write-back runs one amplitude per cycle. No
// new command is taken while a sweep is in flight. A waiting result lets one more
// command in behind it, then holds the engine until the result beat is taken. The
// gate registers may be rewritten whenever the engine is idle. The store is not
// cleared by reset: fill every entry before running a gate.
module quantum_state_vector_gate_engine import qsvge_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [IDX_W-1:0]        i_amp_index,
    input  logic signed [AMP_W-1:0] i_amp_re,
    input  logic signed [AMP_W-1:0] i_amp_im,
    input  logic [QB_W-1:0]         i_target_qubit,
    input  logic [QB_W-1:0]         i_control_qubit,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [AMP_W-1:0] o_read_re,
    output logic signed [AMP_W-1:0] o_read_im,
    output logic [ST_W-1:0]         o_status,
    // gate register write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic signed [AMP_W-1:0] i_cfg_data
);

    t_gate r_gate;

    logic                    r_o_valid;
    logic signed [AMP_W-1:0] r_read_re, r_read_im;
    logic [ST_W-1:0]         r_status;

    t_wr   hwr, bfly_wr, mem_wr;
    t_rd   mem_rd;
    t_tag  tag;
    t_mode mode;
    t_done done;
    t_amp  rdata;
    logic  bfly_busy, out_free;

    // Gate registers always take a beat; the user must change them only while idle (not enforced here)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate.m00.re <= ONE_Q;
            r_gate.m00.im <= '0;
            r_gate.m01.re <= '0;
            r_gate.m01.im <= '0;
            r_gate.m10.re <= '0;
            r_gate.m10.im <= '0;
            r_gate.m11.re <= ONE_Q;
            r_gate.m11.im <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_M00_RE: r_gate.m00.re <= i_cfg_data;
                CFG_M00_IM: r_gate.m00.im <= i_cfg_data;
                CFG_M01_RE: r_gate.m01.re <= i_cfg_data;
                CFG_M01_IM: r_gate.m01.im <= i_cfg_data;
                CFG_M10_RE: r_gate.m10.re <= i_cfg_data;
                CFG_M10_IM: r_gate.m10.im <= i_cfg_data;
                CFG_M11_RE: r_gate.m11.re <= i_cfg_data;
                CFG_M11_IM: r_gate.m11.im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result register frees up in the same cycle its beat is taken
    assign out_free = !r_o_valid || i_ready;

    qsvge_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_amp_index     (i_amp_index),
        .i_amp_re        (i_amp_re),
        .i_amp_im        (i_amp_im),
        .i_target_qubit  (i_target_qubit),
        .i_control_qubit (i_control_qubit),
        .i_busy          (bfly_busy),
        .i_out_free      (out_free),
        .o_hwr           (hwr),
        .o_rd            (mem_rd),
        .o_tag           (tag),
        .o_mode          (mode),
        .o_done          (done)
    );

    // Sweep write-back owns the write port while the pipeline runs; host writes only when idle
    assign mem_wr = bfly_wr.valid ? bfly_wr : hwr;

    qsvge_store u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_rd    (mem_rd),
        .o_rdata (rdata)
    );

    qsvge_bfly u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (rdata),
        .i_tag   (tag),
        .i_mode  (mode),
        .i_gate  (r_gate),
        .o_wr    (bfly_wr),
        .o_busy  (bfly_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (done.load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Read data is still held by the RAM output: nothing reads between accept and load
    always_ff @(posedge i_clk) begin
        if (done.load) begin
            r_read_re <= done.is_read ? rdata.re : '0;
            r_read_im <= done.is_read ? rdata.im : '0;
            r_status  <= done.status;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_read_re = r_read_re;
    assign o_read_im = r_read_im;
    assign o_status  = r_status;

`ifndef SYNTH
    // Host writes never land on top of sweep write-back
    a_wr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hwr.valid |-> !bfly_wr.valid)
        else $error("host write collides with sweep write-back");

    // An entry is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr.valid && mem_rd.en) |-> (mem_wr.addr != mem_rd.addr))
        else $error("read and write hit the same entry");

    // A result is only loaded once the sweep has fully drained
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.load |-> !bfly_busy)
        else $error("result loaded with write-back still in flight");

    // No command is taken while the pipeline holds sweep work
    a_hold_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bfly_busy |-> !o_ready)
        else $error("command accepted during a sweep");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the state-vector gate engine: command stream, gate loads, scoreboard.
`timescale 1ns / 100ps

module testbench;
    import qsvge_pkg::*;

    // Run shape
    localparam int NCOEF      = 8;
    localparam int RAND_ITEMS = 580;
    localparam int PHASES     = 6;
    // Assume every beat of the run is a sweep and add stalls and sender gaps, then allow
    // several times that before declaring a hang.
    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    // Quiet cycles after the last result: covers the sweep tail with plenty to spare
    localparam int SETTLE = 40;

    // One command beat, with an optional pinned result for the directed rows
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        idx;
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
        logic [QB_W-1:0]         tq;
        logic [QB_W-1:0]         cq;
        logic                    pinned;
        logic signed [AMP_W-1:0] exp_re;
        logic signed [AMP_W-1:0] exp_im;
        logic [ST_W-1:0]         exp_st;
    } t_cmd_row;

    // One result beat
    typedef struct packed {
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
        logic [ST_W-1:0]         st;
    } t_reply;

    // DUT ports; every input starts at a known value
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_valid         = 1'b0;
    logic                    o_ready;
    logic [CMD_W-1:0]        i_cmd           = CMD_WRITE;
    logic [IDX_W-1:0]        i_amp_index     = '0;
    logic signed [AMP_W-1:0] i_amp_re        = '0;
    logic signed [AMP_W-1:0] i_amp_im        = '0;
    logic [QB_W-1:0]         i_target_qubit  = '0;
    logic [QB_W-1:0]         i_control_qubit = '0;
    logic                    o_valid;
    logic                    i_ready         = 1'b0;
    logic signed [AMP_W-1:0] o_read_re;
    logic signed [AMP_W-1:0] o_read_im;
    logic [ST_W-1:0]         o_status;
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = CFG_M00_RE;
    logic signed [AMP_W-1:0] i_cfg_data      = '0;

    // Mirror of the engine: amplitude store, gate coefficients, results still owed
    t_amp                    amp_mirror [NENT];
    logic signed [AMP_W-1:0] gate_coef [NCOEF] = '{ONE_Q, 16'sd0, 16'sd0, 16'sd0,
                                                   16'sd0, 16'sd0, ONE_Q, 16'sd0};
    t_reply                  pending_replies [$];

    // Traffic shaping, percentages per cycle
    int     idle_pct   = 0;
    int     stall_pct  = 0;
    int     mismatches = 0;
    longint cycles     = 0;

    // Directed rows. Rows with a pinned result check a value that is obvious from the row
    // itself; the rest go through the mirror.
    t_cmd_row directed_plan [22] = '{
        // rail values, zero and small values written and read straight back
        '{CMD_WRITE, 10'd0,    16'sh7FFF, 16'sh8000, 4'd0,  4'd0,  1'b1, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b1,
          16'sh7FFF, 16'sh8000, ST_OK},
        '{CMD_WRITE, 10'd1023, 16'sh8000, 16'sh7FFF, 4'd15, 4'd15, 1'b1, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd1023, 16'shFFFF, 16'shFFFF, 4'd15, 4'd15, 1'b1,
          16'sh8000, 16'sh7FFF, ST_OK},
        '{CMD_WRITE, 10'd512,  16'sh0000, 16'sh0000, 4'd3,  4'd7,  1'b1, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd512,  16'sh5555, 16'shAAAA, 4'd9,  4'd2,  1'b1, 16'sh0, 16'sh0, ST_OK},
        '{CMD_WRITE, 10'd341,  16'shFFFF, 16'sh0001, 4'd10, 4'd5,  1'b1, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd341,  16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b1,
          16'shFFFF, 16'sh0001, ST_OK},
        // identity gate at the lowest and highest qubit
        '{CMD_GATE,  10'd0,    16'sh1234, 16'sh4321, 4'd0,  4'd9,  1'b0, 16'sh0, 16'sh0, ST_OK},
        '{CMD_GATE,  10'd682,  16'sh0000, 16'sh0000, 4'd9,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK},
        // gate on a qubit past the store
        '{CMD_GATE,  10'd0,    16'sh0000, 16'sh0000, 4'd10, 4'd0,  1'b1, 16'sh0, 16'sh0,
          ST_RANGE},
        '{CMD_GATE,  10'd1023, 16'sh7FFF, 16'sh8000, 4'd15, 4'd15, 1'b1, 16'sh0, 16'sh0,
          ST_RANGE},
        // CNOT both ways across the full width
        '{CMD_CNOT,  10'd0,    16'sh0000, 16'sh0000, 4'd9,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK},
        '{CMD_CNOT,  10'd1023, 16'shFFFF, 16'shFFFF, 4'd0,  4'd9,  1'b0, 16'sh0, 16'sh0, ST_OK},
        // control equals target
        '{CMD_CNOT,  10'd0,    16'sh0000, 16'sh0000, 4'd5,  4'd5,  1'b1, 16'sh0, 16'sh0,
          ST_EQUAL},
        // control or target out of range; the range check wins over equality
        '{CMD_CNOT,  10'd0,    16'sh0000, 16'sh0000, 4'd3,  4'd12, 1'b1, 16'sh0, 16'sh0,
          ST_RANGE},
        '{CMD_CNOT,  10'd0,    16'sh0000, 16'sh0000, 4'd15, 4'd3,  1'b1, 16'sh0, 16'sh0,
          ST_RANGE},
        '{CMD_CNOT,  10'd0,    16'sh0000, 16'sh0000, 4'd10, 4'd10, 1'b1, 16'sh0, 16'sh0,
          ST_RANGE},
        // read back what the sweeps left behind
        '{CMD_READ,  10'd0,    16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd1023, 16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd512,  16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK},
        '{CMD_READ,  10'd341,  16'sh0000, 16'sh0000, 4'd0,  4'd0,  1'b0, 16'sh0, 16'sh0, ST_OK}
    };

    quantum_state_vector_gate_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_amp_index     (i_amp_index),
        .i_amp_re        (i_amp_re),
        .i_amp_im        (i_amp_im),
        .i_target_qubit  (i_target_qubit),
        .i_control_qubit (i_control_qubit),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_re       (o_read_re),
        .o_read_im       (o_read_im),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Round a Q6.28 sum to nearest, ties upward, and clamp it to Q2.14
    function automatic logic signed [AMP_W-1:0] q14_round(input longint acc);
        longint q;
        q = (acc + 8192) >>> FRAC_W;
        if (q > 32767) return 16'sh7FFF;
        if (q < -32768) return 16'sh8000;
        return q[AMP_W-1:0];
    endfunction

    // One output of the 2x2 gate: row base selects m00/m01 or m10/m11
    function automatic t_amp mix_pair(input int base, input t_amp a0, input t_amp a1);
        longint r0, i0, r1, i1, sr, si;
        t_amp   mixed;
        r0 = gate_coef[base];
        i0 = gate_coef[base + 1];
        r1 = gate_coef[base + 2];
        i1 = gate_coef[base + 3];
        sr = r0 * longint'(a0.re) - i0 * longint'(a0.im)
           + r1 * longint'(a1.re) - i1 * longint'(a1.im);
        si = r0 * longint'(a0.im) + i0 * longint'(a0.re)
           + r1 * longint'(a1.im) + i1 * longint'(a1.re);
        mixed.re = q14_round(sr);
        mixed.im = q14_round(si);
        return mixed;
    endfunction

    // Advance the mirror by one command and return the result beat it owes
    function automatic t_reply apply_command(input t_cmd_row c);
        t_reply rep;
        t_amp   a0, a1;
        int     tq, cq;
        rep = '0;
        rep.st = ST_OK;
        tq = int'(c.tq);
        cq = int'(c.cq);
        case (c.cmd)
            CMD_WRITE: begin
                amp_mirror[c.idx].re = c.re;
                amp_mirror[c.idx].im = c.im;
            end
            CMD_READ: begin
                rep.re = amp_mirror[c.idx].re;
                rep.im = amp_mirror[c.idx].im;
            end
            CMD_GATE: begin
                if (tq >= QUBITS) begin
                    rep.st = ST_RANGE;
                end else begin
                    for (int i = 0; i < NENT; i++) begin
                        if (((i >> tq) & 1) == 0) begin
                            a0 = amp_mirror[i];
                            a1 = amp_mirror[i | (1 << tq)];
                            amp_mirror[i]             = mix_pair(CFG_M00_RE, a0, a1);
                            amp_mirror[i | (1 << tq)] = mix_pair(CFG_M10_RE, a0, a1);
                        end
                    end
                end
            end
            CMD_CNOT: begin
                if (tq >= QUBITS || cq >= QUBITS) begin
                    rep.st = ST_RANGE;
                end else if (tq == cq) begin
                    rep.st = ST_EQUAL;
                end else begin
                    // swap the pair wherever the control bit is set
                    for (int i = 0; i < NENT; i++) begin
                        if (((i >> cq) & 1) == 1 && ((i >> tq) & 1) == 0) begin
                            a0 = amp_mirror[i];
                            amp_mirror[i] = amp_mirror[i | (1 << tq)];
                            amp_mirror[i | (1 << tq)] = a0;
                        end
                    end
                end
            end
        endcase
        return rep;
    endfunction

    // Amplitude value weighted towards the rails and towards zero
    function automatic logic signed [AMP_W-1:0] rand_amp();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return AMP_W'($signed($urandom_range(64)) - 32);
            default: return AMP_W'($urandom);
        endcase
    endfunction

    // Random command: mostly well-formed, with a share of bad qubits and equal pairs
    function automatic t_cmd_row rand_row();
        t_cmd_row r;
        int       pick;
        r = '0;
        r.idx = IDX_W'($urandom);
        r.re  = rand_amp();
        r.im  = rand_amp();
        r.tq  = QB_W'($urandom);
        r.cq  = QB_W'($urandom);
        pick  = $urandom_range(99);
        if (pick < 38) begin
            r.cmd = CMD_WRITE;
        end else if (pick < 72) begin
            r.cmd = CMD_READ;
        end else if (pick < 86) begin
            r.cmd = CMD_GATE;
            if ($urandom_range(99) < 85) r.tq = QB_W'($urandom_range(QUBITS - 1));
        end else begin
            r.cmd = CMD_CNOT;
            pick  = $urandom_range(99);
            if (pick < 75) begin
                r.tq = QB_W'($urandom_range(QUBITS - 1));
                r.cq = QB_W'((int'(r.tq) + $urandom_range(QUBITS - 1, 1)) % QUBITS);
            end else if (pick < 87) begin
                r.tq = QB_W'($urandom_range(QUBITS - 1));
                r.cq = r.tq;
            end
            // otherwise leave both fully random, mostly out of range
        end
        return r;
    endfunction

    // Present one command beat, hold it until accepted, then book its result
    task automatic issue(input t_cmd_row c);
        t_reply pinned_rep;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid         <= 1'b1;
        i_cmd           <= c.cmd;
        i_amp_index     <= c.idx;
        i_amp_re        <= c.re;
        i_amp_im        <= c.im;
        i_target_qubit  <= c.tq;
        i_control_qubit <= c.cq;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        if (c.pinned) begin
            void'(apply_command(c));
            pinned_rep.re = c.exp_re;
            pinned_rep.im = c.exp_im;
            pinned_rep.st = c.exp_st;
            pending_replies.push_back(pinned_rep);
        end else begin
            pending_replies.push_back(apply_command(c));
        end
    endtask

    // Drop valid and hold off until every owed result is in and the sweep tail has passed
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Load all eight gate coefficients, one beat per register
    task automatic load_gate(input logic signed [AMP_W-1:0] coef [NCOEF]);
        for (int k = CFG_M00_RE; k <= CFG_M11_IM; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= coef[k];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1) @(posedge i_clk);
            gate_coef[k] = coef[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure and in-order comparison against the mirror
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: re %0d im %0d status %0d",
                             o_read_re, o_read_im, o_status);
            end else begin
                want = pending_replies.pop_front();
                if (o_read_re !== want.re || o_read_im !== want.im || o_status !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected re %0d im %0d status %0d, got re %0d im %0d status %0d",
                                 want.re, want.im, want.st, o_read_re, o_read_im, o_status);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL quantum_state_vector_gate_engine");
            $finish;
        end
    end

    initial begin
        t_cmd_row                row;
        logic signed [AMP_W-1:0] coef [NCOEF];

        // Hold reset, then release it once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every entry first: the store is undefined until written and sweeps need it whole
        for (int i = 0; i < NENT; i++) begin
            row     = '0;
            row.cmd = CMD_WRITE;
            row.idx = IDX_W'(i);
            row.re  = rand_amp();
            row.im  = rand_amp();
            row.tq  = QB_W'($urandom);
            row.cq  = QB_W'($urandom);
            issue(row);
        end

        // Directed rows under the reset (identity) gate, with mild traffic shaping
        idle_pct  = 30;
        stall_pct = 30;
        foreach (directed_plan[k]) issue(directed_plan[k]);

        // Random phases; all but the first load a new gate while idle; shaping rotates over four settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: begin
                    // Hadamard
                    coef = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0,
                             16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
                    load_gate(coef);
                end
                2: begin
                    // negative rail everywhere: drives the sums into saturation
                    foreach (coef[k]) coef[k] = 16'sh8000;
                    load_gate(coef);
                end
                3: begin
                    foreach (coef[k]) coef[k] = 16'sh7FFF;
                    load_gate(coef);
                end
                4: begin
                    foreach (coef[k]) coef[k] = rand_amp();
                    load_gate(coef);
                end
                5: begin
                    // Pauli Y: purely imaginary off-diagonal
                    coef = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384,
                             16'sd0, 16'sd16384, 16'sd0, 16'sd0};
                    load_gate(coef);
                end
                default: begin
                    // keep the reset identity
                end
            endcase
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
                // now and then let the engine run dry before the next beat
                if ($urandom_range(99) < 2) drain();
                issue(rand_row());
            end
        end

        drain();
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("PASS quantum_state_vector_gate_engine");
        end else begin
            $display("FAIL quantum_state_vector_gate_engine");
        end
        $finish;
    end

endmodule
